[sv/spi_rd12_pkg.sv]
package spi_rd12_pkg;

    localparam int CMD_BITS    = 8;
    localparam int READ_CLOCKS = 16;
    localparam int KEEP_BITS   = 12;
    localparam int CNT_W       = 5;
    localparam int DELAY_W     = 16;

    typedef struct packed {
        logic       kind;
        logic [7:0] command;
        logic       miso_in;
    } spi_rd12_in_t;

    typedef struct packed {
        logic        chip_select_n;
        logic        sclk_out;
        logic        mosi_out;
        logic        busy_res;
        logic        done_res;
        logic [11:0] read_word;
    } spi_rd12_out_t;

endpackage

[sv/spi_rd12_in_stage.sv]
module spi_rd12_in_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  spi_rd12_pkg::spi_rd12_in_t in_data,
    output logic                       item_valid,
    input  logic                       item_take,
    output spi_rd12_pkg::spi_rd12_in_t item_data
);
    import spi_rd12_pkg::*;

    logic         vld_reg;
    logic         vld_next;
    spi_rd12_in_t data_reg;

    assign in_ready = !vld_reg || item_take;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_ready)
        begin
            vld_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = vld_reg;
    assign item_data  = data_reg;

endmodule

[sv/spi_rd12_seq.sv]
module spi_rd12_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [15:0]                 edge_delay,
    input  logic                        item_valid,
    output logic                        item_take,
    input  spi_rd12_pkg::spi_rd12_in_t  item_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output spi_rd12_pkg::spi_rd12_out_t out_data
);
    import spi_rd12_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD_LOW,
        PH_CMD_HIGH,
        PH_CMD_END,
        PH_RD_HIGH,
        PH_RD_LOW,
        PH_SAMPLE
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     count_reg, count_next, count_inc;
    logic [CMD_BITS-1:0]  cmd_reg, cmd_next;
    logic [KEEP_BITS-1:0] rx_reg, rx_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic                 cs_reg, cs_next;
    logic                 sclk_reg, sclk_next;
    logic                 mosi_reg, mosi_next;
    logic                 done_next;
    logic [KEEP_BITS-1:0] word_next;
    logic                 out_vld_reg, out_vld_next;
    spi_rd12_out_t        out_reg, out_next;

    assign item_take = item_valid && (!out_vld_reg || out_ready);
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        rx_next    = rx_reg;
        delay_next = delay_reg;
        cs_next    = cs_reg;
        sclk_next  = sclk_reg;
        mosi_next  = mosi_reg;
        done_next  = 1'b0;
        word_next  = '0;
        if (phase_reg == PH_IDLE)
        begin
            if (item_data.kind)
            begin
                cs_next    = 1'b0;
                cmd_next   = item_data.command[CMD_BITS-1:0];
                rx_next    = '0;
                count_next = '0;
                phase_next = PH_CMD_LOW;
                delay_next = edge_delay;
            end
        end
        else if (delay_reg != '0)
        begin
            delay_next = delay_reg - 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_CMD_LOW:
                begin
                    sclk_next  = 1'b0;
                    phase_next = PH_CMD_HIGH;
                    delay_next = edge_delay;
                end
                PH_CMD_HIGH:
                begin
                    mosi_next  = cmd_reg[CMD_BITS-1];
                    cmd_next   = cmd_reg << 1;
                    sclk_next  = 1'b1;
                    delay_next = edge_delay;
                    if (count_inc >= CNT_W'(CMD_BITS))
                    begin
                        count_next = '0;
                        phase_next = PH_CMD_END;
                    end
                    else
                    begin
                        count_next = count_inc;
                        phase_next = PH_CMD_LOW;
                    end
                end
                PH_CMD_END:
                begin
                    sclk_next  = 1'b0;
                    phase_next = PH_RD_HIGH;
                    delay_next = edge_delay;
                end
                PH_RD_HIGH:
                begin
                    sclk_next  = 1'b1;
                    phase_next = PH_RD_LOW;
                    delay_next = edge_delay;
                end
                PH_RD_LOW:
                begin
                    sclk_next  = 1'b0;
                    phase_next = PH_SAMPLE;
                    delay_next = edge_delay;
                end
                PH_SAMPLE:
                begin
                    if (count_reg < CNT_W'(KEEP_BITS))
                    begin
                        rx_next = {rx_reg[KEEP_BITS-2:0], item_data.miso_in};
                    end
                    if (count_inc >= CNT_W'(READ_CLOCKS))
                    begin
                        cs_next    = 1'b1;
                        done_next  = 1'b1;
                        word_next  = rx_next;
                        count_next = '0;
                        delay_next = '0;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        count_next = count_inc;
                        sclk_next  = 1'b1;
                        phase_next = PH_RD_LOW;
                        delay_next = edge_delay;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        out_next.chip_select_n = cs_next;
        out_next.sclk_out      = sclk_next;
        out_next.mosi_out      = mosi_next;
        out_next.busy_res      = (phase_next != PH_IDLE);
        out_next.done_res      = done_next;
        out_next.read_word     = word_next;
        out_vld_next = out_vld_reg;
        if (!out_vld_reg || out_ready)
        begin
            out_vld_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            cmd_reg     <= '0;
            rx_reg      <= '0;
            delay_reg   <= '0;
            cs_reg      <= 1'b1;
            sclk_reg    <= 1'b1;
            mosi_reg    <= 1'b1;
            out_vld_reg <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (item_take)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                cmd_reg   <= cmd_next;
                rx_reg    <= rx_next;
                delay_reg <= delay_next;
                cs_reg    <= cs_next;
                sclk_reg  <= sclk_next;
                mosi_reg  <= mosi_next;
                out_reg   <= out_next;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

[sv/spi_cmd_read12_master_unit.sv]
// This block sequences a bit-banged SPI read: a command byte goes out MSB first,
// then sixteen read clocks follow and the first twelve MISO samples form the word.
// Each request on the input channel is one clock tick of the pin sequence; it
// carries a start flag, the command byte and the current MISO level.
// Each request produces exactly one result request with the pin levels, the busy
// flag, a one-tick done flag and the received word, which is zero except with done.
// A request is held in an input register and moves into the result register when
// that register is empty or its result is being taken, so each result is
// registered and can be taken when the receiver is ready.
// One request is accepted in every cycle while the receiver does not stall; the
// state update of the pin sequence is the only logic between the two registers.
// When the receiver stalls, the result register holds its request and the input
// register takes one more; input ready falls only when both are full.
// The edge_delay register is written through cfg_we and cfg_wdata; the user must write
// it only while no request is in flight, as the block itself does not enforce this.
// Reset sets chip select, SCLK and MOSI high, clears the sequencer to idle, sets
// edge_delay to zero and empties both registers.
module spi_cmd_read12_master_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  spi_rd12_pkg::spi_rd12_in_t  in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output spi_rd12_pkg::spi_rd12_out_t out_data,
    input  logic                        cfg_we,
    input  logic [15:0]                 cfg_wdata
);
    import spi_rd12_pkg::*;

    logic [DELAY_W-1:0] edge_delay_reg;
    logic               item_valid;
    logic               item_take;
    spi_rd12_in_t       item_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_delay_reg <= '0;
        end
        else if (cfg_we)
        begin
            edge_delay_reg <= cfg_wdata;
        end
    end

    spi_rd12_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item_data  (item_data)
    );

    spi_rd12_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_delay (edge_delay_reg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item_data  (item_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    import spi_rd12_pkg::*;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CMD_LOW,
        SEQ_CMD_HIGH,
        SEQ_CMD_END,
        SEQ_RD_HIGH,
        SEQ_RD_LOW,
        SEQ_SAMPLE
    } seq_phase_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    spi_rd12_in_t  in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    spi_rd12_out_t out_data;
    logic          cfg_we = 1'b0;
    logic [15:0]   cfg_wdata = '0;

    spi_rd12_in_t  pending_reqs[$];
    spi_rd12_out_t expected_results[$];
    spi_rd12_out_t want_result;

    int burst_left = 1;
    int gap_left = 0;
    logic [7:0] ready_pattern = 8'hFF;
    logic [4:0] pattern_age = '0;

    int error_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int reads_done = 0;

    // Local copy of the sequencer state and of the edge delay register.
    seq_phase_t  seq_phase = SEQ_IDLE;
    logic [4:0]  seq_bits = '0;
    logic [7:0]  cmd_shift = '0;
    logic [11:0] rx_word = '0;
    logic [15:0] wait_count = '0;
    logic        cs_level = 1'b1;
    logic        sclk_level = 1'b1;
    logic        mosi_level = 1'b1;
    logic [15:0] edge_delay_cfg = '0;

    spi_cmd_read12_master_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic spi_rd12_out_t spi_tick(input spi_rd12_in_t req);
        spi_rd12_out_t res;
        res = '0;
        if (seq_phase == SEQ_IDLE)
        begin
            if (req.kind)
            begin
                cs_level = 1'b0;
                cmd_shift = req.command;
                rx_word = '0;
                seq_bits = '0;
                seq_phase = SEQ_CMD_LOW;
                wait_count = edge_delay_cfg;
            end
        end
        else if (wait_count != 0)
        begin
            wait_count = wait_count - 16'd1;
        end
        else
        begin
            case (seq_phase)
                SEQ_CMD_LOW:
                begin
                    sclk_level = 1'b0;
                    seq_phase = SEQ_CMD_HIGH;
                    wait_count = edge_delay_cfg;
                end
                SEQ_CMD_HIGH:
                begin
                    mosi_level = cmd_shift[CMD_BITS-1];
                    cmd_shift = cmd_shift << 1;
                    sclk_level = 1'b1;
                    seq_bits = seq_bits + 5'd1;
                    if (seq_bits >= CMD_BITS)
                    begin
                        seq_bits = '0;
                        seq_phase = SEQ_CMD_END;
                    end
                    else
                    begin
                        seq_phase = SEQ_CMD_LOW;
                    end
                    wait_count = edge_delay_cfg;
                end
                SEQ_CMD_END:
                begin
                    sclk_level = 1'b0;
                    seq_phase = SEQ_RD_HIGH;
                    wait_count = edge_delay_cfg;
                end
                SEQ_RD_HIGH:
                begin
                    sclk_level = 1'b1;
                    seq_phase = SEQ_RD_LOW;
                    wait_count = edge_delay_cfg;
                end
                SEQ_RD_LOW:
                begin
                    sclk_level = 1'b0;
                    seq_phase = SEQ_SAMPLE;
                    wait_count = edge_delay_cfg;
                end
                SEQ_SAMPLE:
                begin
                    if (seq_bits < KEEP_BITS)
                    begin
                        rx_word = {rx_word[10:0], req.miso_in};
                    end
                    seq_bits = seq_bits + 5'd1;
                    if (seq_bits >= READ_CLOCKS)
                    begin
                        cs_level = 1'b1;
                        res.done_res = 1'b1;
                        res.read_word = rx_word;
                        seq_bits = '0;
                        wait_count = '0;
                        seq_phase = SEQ_IDLE;
                    end
                    else
                    begin
                        sclk_level = 1'b1;
                        seq_phase = SEQ_RD_LOW;
                        wait_count = edge_delay_cfg;
                    end
                end
                default:
                begin
                    seq_phase = SEQ_IDLE;
                end
            endcase
        end
        res.chip_select_n = cs_level;
        res.sclk_out = sclk_level;
        res.mosi_out = mosi_level;
        res.busy_res = (seq_phase != SEQ_IDLE);
        return res;
    endfunction

    function automatic spi_rd12_in_t random_req();
        spi_rd12_in_t req;
        req.kind = ($urandom_range(0, 99) < 15);
        req.command = 8'($urandom);
        req.miso_in = 1'($urandom);
        return req;
    endfunction

    function automatic spi_rd12_in_t make_req(input logic kind, input logic [7:0] command,
                                              input logic miso);
        spi_rd12_in_t req;
        req.kind = kind;
        req.command = command;
        req.miso_in = miso;
        return req;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic queue_random(input int count);
        repeat (count)
        begin
            pending_reqs.push_back(random_req());
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic write_edge_delay(input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        edge_delay_cfg = value;
    endtask

    // The sender issues requests in bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            burst_left <= 1;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(spi_tick(in_data));
                sent_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_reqs.pop_front();
                    if (burst_left > 1)
                    begin
                        burst_left <= burst_left - 1;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver rotates a stall pattern and picks a new one each time its 5-bit age counter wraps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_pattern <= 8'hFF;
            pattern_age <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                checked_count++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, got %h", $time, out_data);
                    error_count++;
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    check_field("chip_select_n", want_result.chip_select_n,
                                out_data.chip_select_n);
                    check_field("sclk_out", want_result.sclk_out, out_data.sclk_out);
                    check_field("mosi_out", want_result.mosi_out, out_data.mosi_out);
                    check_field("busy_res", want_result.busy_res, out_data.busy_res);
                    check_field("done_res", want_result.done_res, out_data.done_res);
                    check_field("read_word", want_result.read_word, out_data.read_word);
                    if (want_result.done_res)
                    begin
                        reads_done++;
                    end
                end
            end
            pattern_age <= pattern_age + 5'd1;
            if (pattern_age == 5'd31)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    ready_pattern <= 8'hFF;
                end
                else
                begin
                    ready_pattern <= 8'($urandom_range(1, 255));
                end
            end
            else
            begin
                ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
            end
            out_ready <= ready_pattern[0];
        end
    end

    initial
    begin
        int i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Idle ticks, a start with an all-ones command, then starts that arrive while busy.
        pending_reqs.push_back(make_req(1'b0, 8'hFF, 1'b1));
        pending_reqs.push_back(make_req(1'b0, 8'h00, 1'b0));
        pending_reqs.push_back(make_req(1'b1, 8'hFF, 1'b1));
        for (i = 0; i < 19; i++)
        begin
            pending_reqs.push_back(make_req(1'b1, 8'h00, 1'(i)));
        end
        queue_random(280);
        wait_drained();

        write_edge_delay(16'd1);
        queue_random(200);
        wait_drained();

        write_edge_delay(16'd3);
        queue_random(200);
        wait_drained();

        write_edge_delay(16'd0);
        queue_random(150);
        wait_drained();
        queue_random(150);
        wait_drained();

        write_edge_delay(16'hFFFF);
        queue_random(30);
        wait_drained();

        repeat (8) @(posedge clk);
        $display("testbench: %0d requests sent, %0d results checked, %0d reads completed",
                 sent_count, checked_count, reads_done);
        $display("testbench: edge delays of 0, 1, 3 and 65535 ticks were exercised");
        if (error_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

[spi_cmd_read12_master_unit.f]
sv/spi_rd12_pkg.sv
sv/spi_rd12_in_stage.sv
sv/spi_rd12_seq.sv
sv/spi_cmd_read12_master_unit.sv
tb/sv/testbench.sv
